/* rtl/arxf_pkg.sv */
package arxf_pkg;

  localparam int ROUNDS = 32;
  localparam int KEY_W = 96;
  localparam logic [31:0] TWEAK_C = 32'h12345678;

  localparam logic [1:0] CH_HOLD = 2'd0;
  localparam logic [1:0] CH_LOAD = 2'd1;
  localparam logic [1:0] CH_FWD  = 2'd2;
  localparam logic [1:0] CH_BWD  = 2'd3;

  localparam logic CFG_KEY_LO = 1'b0;
  localparam logic CFG_KEY_HI = 1'b1;

  typedef struct packed {
    logic        op;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
  } in_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
  } out_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [KEY_W-1:0] load_key;
  } chain_ctrl_t;

  function automatic logic [31:0] rl(input logic [31:0] x, input int n);
    rl = (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] rr(input logic [31:0] x, input int n);
    rr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] and_mix(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] k);
    and_mix = (rl(b, 1) & rl(b, 8)) ^ a ^ rl(b, 2) ^ k;
  endfunction

  // word 0 in bits 31:0
  function automatic logic [127:0] fwd_round(input logic [127:0] w, input logic [31:0] k0,
                                             input logic [31:0] k1, input logic [31:0] k2);
    logic [31:0] n0;
    logic [31:0] n1;
    logic [31:0] n2;
    logic [31:0] n3;
    n0 = and_mix(w[31:0], w[63:32], k0);
    n1 = rl(w[63:32] + w[95:64], 8) ^ k1;
    n2 = rl(w[95:64] ^ n1, 3);
    n3 = and_mix(w[127:96], w[95:64], k2);
    fwd_round = {n2, n0, n3, n1};
  endfunction

  function automatic logic [127:0] inv_round(input logic [127:0] w, input logic [31:0] k0,
                                             input logic [31:0] k1, input logic [31:0] k2);
    logic [31:0] a1;
    logic [31:0] a2;
    a2 = rr(w[127:96], 3) ^ w[31:0];
    a1 = rr(w[31:0] ^ k1, 8) - a2;
    inv_round = {and_mix(w[63:32], a2, k2), a2, a1, and_mix(w[95:64], a1, k0)};
  endfunction

endpackage

/* rtl/arxf_key_cell.sv */
module arxf_key_cell (
  input  logic                         clk,
  input  logic [1:0]                   mode,
  input  logic [arxf_pkg::KEY_W-1:0]   left_key,
  input  logic [arxf_pkg::KEY_W-1:0]   right_key,
  output logic [arxf_pkg::KEY_W-1:0]   key_q
);

  logic [arxf_pkg::KEY_W-1:0] key_r;

  always_ff @(posedge clk) begin
    case (mode)
      arxf_pkg::CH_LOAD, arxf_pkg::CH_FWD: key_r <= right_key;
      arxf_pkg::CH_BWD: key_r <= left_key;
      default: key_r <= key_r;
    endcase
  end

  assign key_q = key_r;

endmodule

/* rtl/arxf_key_chain.sv */
module arxf_key_chain #(
  parameter int ROUNDS = arxf_pkg::ROUNDS
) (
  input  logic                         clk,
  input  arxf_pkg::chain_ctrl_t        ctrl,
  output logic [arxf_pkg::KEY_W-1:0]   head_key,
  output logic [arxf_pkg::KEY_W-1:0]   tail_key
);

  logic [arxf_pkg::KEY_W-1:0] key_q [ROUNDS];

  // cell 0 is the head, new keys enter at the tail; forward moves toward the head
  for (genvar i = 0; i < ROUNDS; i++) begin : g_cell
    logic [arxf_pkg::KEY_W-1:0] left_key;
    logic [arxf_pkg::KEY_W-1:0] right_key;

    if (i == 0) begin : g_head
      assign left_key = key_q[ROUNDS-1];
    end else begin : g_mid_l
      assign left_key = key_q[i-1];
    end

    if (i == ROUNDS - 1) begin : g_tail
      assign right_key = (ctrl.mode == arxf_pkg::CH_LOAD) ? ctrl.load_key : key_q[0];
    end else begin : g_mid_r
      assign right_key = key_q[i+1];
    end

    arxf_key_cell u_cell (
      .clk      (clk),
      .mode     (ctrl.mode),
      .left_key (left_key),
      .right_key(right_key),
      .key_q    (key_q[i])
    );
  end

  assign head_key = key_q[0];
  assign tail_key = key_q[ROUNDS-1];

endmodule

/* rtl/arx_feistel_block_cipher_128.sv */
// 128-bit four-branch arx feistel cipher, encrypt or decrypt per word.
// input channel: in_valid/in_stall carry op and the block; one result word
// leaves on out_valid/out_stall for every input word, in order.
// config channel: cfg_valid/cfg_ready write key_lo (index 0) or key_hi
// (index 1); a key write starts a key expansion, during which in_stall
// and !cfg_ready hold. in_stall is also high while cfg_valid is offered,
// so a key write wins.
// round keys live in a ring of ROUNDS cells that rotates one step per
// round: forward for encrypt (key read at the head), backward for decrypt
// (key read at the tail), so it is back home after each block.
// rounds run one per cycle in a single round unit, unless the last round
// holds; a new block is taken only once the last round of the current
// one is done.
// the result sits in an output register; a finished result may wait there
// while the next block runs, and the last round holds if it is still not taken.
// reset clears control and the key registers; round keys are undefined
// until the first key write, so blocks must not be sent before it.
module arx_feistel_block_cipher_128 #(
  parameter int ROUNDS = arxf_pkg::ROUNDS
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  arxf_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output arxf_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [0:0]     cfg_index,
  input  logic [63:0]    cfg_data
);

  localparam int CW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam logic [CW-1:0] LAST = CW'(ROUNDS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXP  = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [63:0]   key_lo_r, key_lo_nxt;
  logic [63:0]   key_hi_r, key_hi_nxt;
  logic [127:0]  exp_w_r, exp_w_nxt;
  logic [127:0]  w_r, w_nxt;
  logic          op_r, op_nxt;
  logic          out_valid_r, out_valid_nxt;
  arxf_pkg::out_t out_r, out_nxt;

  arxf_pkg::chain_ctrl_t      ctrl;
  logic [arxf_pkg::KEY_W-1:0] head_key;
  logic [arxf_pkg::KEY_W-1:0] tail_key;
  logic [arxf_pkg::KEY_W-1:0] rkey;
  logic [31:0]                rnd;
  logic [127:0]               round_out;
  logic                       cfg_fire;
  logic                       in_fire;
  logic                       out_free;
  logic                       step;

  arxf_key_chain #(.ROUNDS(ROUNDS)) u_chain (
    .clk     (clk),
    .ctrl    (ctrl),
    .head_key(head_key),
    .tail_key(tail_key)
  );

  assign cfg_ready = (state_r == ST_IDLE);
  assign in_stall  = (state_r != ST_IDLE) | cfg_valid;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign in_fire   = in_valid & ~in_stall;
  assign out_free  = ~out_valid_r | ~out_stall;
  assign step      = (state_r == ST_RUN) & ((cnt_r != LAST) | out_free);
  assign rnd       = {{(32-CW){1'b0}}, cnt_r};

  assign rkey = op_r ? tail_key : head_key;
  assign round_out = op_r ? arxf_pkg::inv_round(w_r, rkey[31:0], rkey[63:32], rkey[95:64])
                          : arxf_pkg::fwd_round(w_r, rkey[31:0], rkey[63:32], rkey[95:64]);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    key_lo_nxt    = key_lo_r;
    key_hi_nxt    = key_hi_r;
    exp_w_nxt     = exp_w_r;
    w_nxt         = w_r;
    op_nxt        = op_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_nxt       = out_r;
    ctrl.mode     = arxf_pkg::CH_HOLD;
    ctrl.load_key = exp_w_r[95:0];

    case (state_r)
      ST_IDLE: begin
        if (cfg_fire) begin
          if (cfg_index == arxf_pkg::CFG_KEY_LO) begin
            key_lo_nxt = cfg_data;
          end else begin
            key_hi_nxt = cfg_data;
          end
          exp_w_nxt = {key_hi_nxt, key_lo_nxt};
          cnt_nxt   = '0;
          state_nxt = ST_EXP;
        end else if (in_fire) begin
          w_nxt     = {in_data.block_hi, in_data.block_lo};
          op_nxt    = in_data.op;
          cnt_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_EXP: begin
        ctrl.mode = arxf_pkg::CH_LOAD;
        exp_w_nxt = arxf_pkg::fwd_round(exp_w_r, rnd, rnd << 16, rnd + arxf_pkg::TWEAK_C);
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RUN: begin
        if (step) begin
          ctrl.mode = op_r ? arxf_pkg::CH_BWD : arxf_pkg::CH_FWD;
          w_nxt     = round_out;
          cnt_nxt   = cnt_r + 1'b1;
          if (cnt_r == LAST) begin
            out_nxt.result_lo = round_out[63:0];
            out_nxt.result_hi = round_out[127:64];
            out_valid_nxt     = 1'b1;
            state_nxt         = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      key_lo_r    <= '0;
      key_hi_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      key_lo_r    <= key_lo_nxt;
      key_hi_r    <= key_hi_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    exp_w_r <= exp_w_nxt;
    w_r     <= w_nxt;
    op_r    <= op_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* dv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NROUNDS = arxf_pkg::ROUNDS;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef enum logic {OP_ENC = 1'b0, OP_DEC = 1'b1} cipher_op_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  arxf_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  arxf_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = arxf_pkg::CFG_KEY_LO;
  logic [63:0] cfg_data = '0;

  always #10 clk = ~clk;

  arx_feistel_block_cipher_128 dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  class cipher_scoreboard;
    logic [63:0] key_lo_q;
    logic [63:0] key_hi_q;
    logic [31:0] sched[3*NROUNDS];
    arxf_pkg::out_t expected_words[$];
    int errors;

    function new();
      key_lo_q = '0;
      key_hi_q = '0;
      errors = 0;
    endfunction

    static function logic [31:0] rotl(logic [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
    endfunction

    static function logic [31:0] rotr(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    static function logic [31:0] mix(logic [31:0] a, logic [31:0] b, logic [31:0] k);
      return (rotl(b, 1) & rotl(b, 8)) ^ a ^ rotl(b, 2) ^ k;
    endfunction

    static function void enc_round(ref logic [31:0] w[4], input logic [31:0] k0,
                                   input logic [31:0] k1, input logic [31:0] k2);
      logic [31:0] n0, n1, n2, n3;
      n0 = mix(w[0], w[1], k0);
      n1 = rotl(w[1] + w[2], 8) ^ k1;
      n2 = rotl(w[2] ^ n1, 3);
      n3 = mix(w[3], w[2], k2);
      w[0] = n1; w[1] = n3; w[2] = n0; w[3] = n2;
    endfunction

    static function void dec_round(ref logic [31:0] w[4], input logic [31:0] k0,
                                   input logic [31:0] k1, input logic [31:0] k2);
      logic [31:0] a1, a2, n0, n3;
      n3 = w[1];
      n0 = w[2];
      a2 = rotr(w[3], 3) ^ w[0];
      a1 = rotr(w[0] ^ k1, 8) - a2;
      w[0] = mix(n0, a1, k0);
      w[1] = a1;
      w[2] = a2;
      w[3] = mix(n3, a2, k2);
    endfunction

    function void write_key(logic [0:0] idx, logic [63:0] val);
      logic [31:0] w[4];
      if (idx == arxf_pkg::CFG_KEY_LO) key_lo_q = val;
      else key_hi_q = val;
      w[0] = key_lo_q[31:0]; w[1] = key_lo_q[63:32];
      w[2] = key_hi_q[31:0]; w[3] = key_hi_q[63:32];
      for (int r = 0; r < NROUNDS; r++) begin
        sched[3*r] = w[0]; sched[3*r+1] = w[1]; sched[3*r+2] = w[2];
        enc_round(w, r, r << 16, r + arxf_pkg::TWEAK_C);
      end
    endfunction

    function void note_block(arxf_pkg::in_t item);
      logic [31:0] w[4];
      arxf_pkg::out_t res;
      w[0] = item.block_lo[31:0]; w[1] = item.block_lo[63:32];
      w[2] = item.block_hi[31:0]; w[3] = item.block_hi[63:32];
      if (item.op == OP_ENC) begin
        for (int r = 0; r < NROUNDS; r++)
          enc_round(w, sched[3*r], sched[3*r+1], sched[3*r+2]);
      end else begin
        for (int r = NROUNDS - 1; r >= 0; r--)
          dec_round(w, sched[3*r], sched[3*r+1], sched[3*r+2]);
      end
      res.result_lo = {w[1], w[0]};
      res.result_hi = {w[3], w[2]};
      expected_words.push_back(res);
    endfunction

    function void check_result(arxf_pkg::out_t got);
      arxf_pkg::out_t want;
      if (expected_words.size() == 0) begin
        $error("unexpected result word %h", got);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      if (got.result_lo !== want.result_lo) begin
        $error("result_lo expected %h actual %h", want.result_lo, got.result_lo);
        errors++;
      end
      if (got.result_hi !== want.result_hi) begin
        $error("result_hi expected %h actual %h", want.result_hi, got.result_hi);
        errors++;
      end
    endfunction
  endclass

  cipher_scoreboard sb = new();
  bit quiet_tail = 1'b0;
  bit hold_off = 1'b0;
  int idle_cycles = 0;

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_block(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // receiver stall bursts
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        for (int i = 0; i < 400; i++) @(negedge clk);
        hold_off = 1'b0;
        out_stall <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 15);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_key_reg(logic [0:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_key(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_block(cipher_op_e op, logic [63:0] lo, logic [63:0] hi);
    arxf_pkg::in_t item;
    item.op = op;
    item.block_lo = lo;
    item.block_hi = hi;
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(negedge clk);
    repeat (NROUNDS + 4) @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  initial begin
    logic [63:0] lo, hi, a, b;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_key_reg(arxf_pkg::CFG_KEY_LO, '0);
    write_key_reg(arxf_pkg::CFG_KEY_HI, '0);
    // extremes of the block, both operations
    send_block(OP_ENC, '0, '0);
    send_block(OP_DEC, '0, '0);
    send_block(OP_ENC, '1, '1);
    send_block(OP_DEC, '1, '1);
    drain();
    write_key_reg(arxf_pkg::CFG_KEY_LO, '1);
    write_key_reg(arxf_pkg::CFG_KEY_HI, '1);
    send_block(OP_ENC, '0, '1);
    send_block(OP_DEC, '1, '0);
    send_block(OP_ENC, 64'h0123456789abcdef, 64'hfedcba9876543210);
    send_block(OP_DEC, 64'h8000000000000001, 64'h0000000180000000);
    drain();
    write_key_reg(arxf_pkg::CFG_KEY_LO, 64'h0706050403020100);
    write_key_reg(arxf_pkg::CFG_KEY_HI, 64'h0f0e0d0c0b0a0908);
    send_block(OP_ENC, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    send_block(OP_DEC, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);

    // long receiver hold-off while blocks keep coming
    hold_off = 1'b1;
    for (int i = 0; i < 6; i++) send_block(cipher_op_e'($urandom_range(0, 1)), rand64(), rand64());
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 7) quiet_tail = 1'b1;
      a = rand64();
      b = rand64();
      if ($urandom_range(0, 1)) write_key_reg(arxf_pkg::CFG_KEY_LO, a);
      write_key_reg(arxf_pkg::CFG_KEY_HI, b);
      if (phase == 0) write_key_reg(arxf_pkg::CFG_KEY_LO, a);
      for (int i = 0; i < 140; i++) begin
        // random op on a random block
        lo = rand64();
        hi = rand64();
        send_block(cipher_op_e'($urandom_range(0, 1)), lo, hi);
      end
      drain();
    end

    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

/* filelist.f */
rtl/arxf_pkg.sv
rtl/arxf_key_cell.sv
rtl/arxf_key_chain.sv
rtl/arx_feistel_block_cipher_128.sv
dv/tb_top.sv
